@@ hdl/pfsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_pkg
// Types and constants shared by the protobuf field scan and patch block.
// ----------------------------------------------------------------------------
package pfsp_pkg;

  // Scan phases
  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_VARINT = 3'd1,
    PH_LEN    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_PATCH  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // Reported outcome
  typedef enum logic [1:0] {
    OC_SCAN      = 2'd0,
    OC_PATCHED   = 2'd1,
    OC_MALFORMED = 2'd2,
    OC_NO_FIELD  = 2'd3
  } outcome_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_CODE_LOW  = 2'd0;
  localparam logic [1:0] CFG_CODE_MID  = 2'd1;
  localparam logic [1:0] CFG_CODE_HIGH = 2'd2;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam int          FIXED64_BYTES    = 8;
  localparam int          FIXED32_BYTES    = 4;
  localparam int          VARINT_MAX_BYTES = 10;
  localparam int          CODE_BYTES       = 20;
  localparam logic [31:0] PATCH_FIELD      = 32'd2;
  localparam logic [63:0] PATCH_LEN        = 64'd20;

  // Scanner state that does not depend on the message size
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  vcnt;       // varint bytes seen, shift = 7 * vcnt
    logic [63:0] accum;
    logic [31:0] field_num;
    logic [4:0]  code_index;
    outcome_t    outcome;
  } scan_state_t;

  localparam scan_state_t SCAN_REARM = '{
    phase:      PH_KEY,
    vcnt:       4'd0,
    accum:      64'd0,
    field_num:  32'd0,
    code_index: 5'd0,
    outcome:    OC_SCAN
  };

  // No key byte or value pending
  function automatic logic at_boundary(scan_state_t s);
    return (s.phase == PH_KEY) && (s.vcnt == 4'd0);
  endfunction

endpackage

@@ hdl/pfsp_body_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_body_if
// Request channel carrying one message byte with its length and end mark.
// ----------------------------------------------------------------------------
interface pfsp_body_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_byte;
  logic [16:0] body_length;
  logic        last_in;

  modport source (output valid, body_byte, body_length, last_in, input ready);
  modport sink   (input valid, body_byte, body_length, last_in, output ready);
endinterface

@@ hdl/pfsp_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_result_if
// Request channel carrying one output byte and the scan status.
// ----------------------------------------------------------------------------
interface pfsp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       replaced;
  logic [1:0] outcome;
  logic       last_out;

  modport source (output valid, out_byte, replaced, outcome, last_out, input ready);
  modport sink   (input valid, out_byte, replaced, outcome, last_out, output ready);
endinterface

@@ hdl/pfsp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pfsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ hdl/pfsp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_step
// Next-state and output logic of the scanner for one message byte.
// ----------------------------------------------------------------------------
module pfsp_step #(
  parameter int MAX_MESSAGE_BYTES = 65536,
  parameter int PW = $clog2(MAX_MESSAGE_BYTES + 1),
  parameter int LW = (PW > 17) ? PW : 17
) (
  input  pfsp_pkg::scan_state_t cur,
  input  logic [PW-1:0]         pos,
  input  logic [LW-1:0]         skip_cnt,
  input  logic [159:0]          code,
  input  logic [7:0]            body_byte,
  input  logic [16:0]           body_length,
  input  logic                  last_in,
  output pfsp_pkg::scan_state_t st_next,
  output logic [PW-1:0]         pos_next,
  output logic [LW-1:0]         skip_next,
  output logic [7:0]            out_byte,
  output logic                  replaced,
  output pfsp_pkg::outcome_t    res_outcome
);
  import pfsp_pkg::*;

  logic [LW-1:0]         len_ext;
  logic [LW-1:0]         lenc;
  logic [LW:0]           consumed;
  logic [LW-1:0]         left;
  logic [6:0]            shift7;
  logic [63:0]           acc;
  logic [19:0][7:0]      code_arr;
  scan_state_t           nx;

  // Message length clamp and bytes left after this one
  always_comb begin
    len_ext  = LW'(body_length);
    lenc     = (len_ext > LW'(MAX_MESSAGE_BYTES)) ? LW'(MAX_MESSAGE_BYTES) : len_ext;
    consumed = (LW + 1)'(pos) + 1'b1;
    left     = ({1'b0, lenc} > consumed) ? LW'({1'b0, lenc} - consumed) : '0;
    shift7   = 7'(7'(cur.vcnt) * 7'd7);
    acc      = cur.accum | (64'(body_byte[6:0]) << shift7);
  end

  // Next state
  always_comb begin
    nx        = cur;
    skip_next = skip_cnt;
    pos_next  = pos;

    // byte past the message end is not parsed
    if (cur.outcome == OC_SCAN && LW'(pos) >= lenc) begin
      nx.phase   = PH_DONE;
      nx.outcome = at_boundary(cur) ? OC_NO_FIELD : OC_MALFORMED;
    end

    case (nx.phase)
      PH_PATCH: begin
        nx.code_index = cur.code_index + 5'd1;
        if (nx.code_index >= 5'(CODE_BYTES)) nx.phase = PH_DONE;
      end
      PH_SKIP: begin
        if (skip_cnt != '0) skip_next = skip_cnt - 1'b1;
        if (skip_next == '0) nx.phase = PH_KEY;
      end
      PH_KEY, PH_VARINT, PH_LEN: begin
        nx.accum = acc;
        if (body_byte[7]) begin
          nx.vcnt = cur.vcnt + 4'd1;
          if (nx.vcnt >= 4'(VARINT_MAX_BYTES)) begin
            nx.phase   = PH_DONE;
            nx.outcome = OC_MALFORMED;
          end
        end else begin
          nx.accum = '0;
          nx.vcnt  = '0;
          case (cur.phase)
            PH_KEY: begin
              nx.field_num = acc[34:3];
              case (acc[2:0])
                WT_VARINT: nx.phase = PH_VARINT;
                WT_FIXED64: begin
                  if (LW'(FIXED64_BYTES) > left) begin
                    nx.phase   = PH_DONE;
                    nx.outcome = OC_MALFORMED;
                  end else begin
                    skip_next = LW'(FIXED64_BYTES);
                    nx.phase  = PH_SKIP;
                  end
                end
                WT_FIXED32: begin
                  if (LW'(FIXED32_BYTES) > left) begin
                    nx.phase   = PH_DONE;
                    nx.outcome = OC_MALFORMED;
                  end else begin
                    skip_next = LW'(FIXED32_BYTES);
                    nx.phase  = PH_SKIP;
                  end
                end
                WT_LEN: nx.phase = PH_LEN;
                default: begin
                  nx.phase   = PH_DONE;
                  nx.outcome = OC_MALFORMED;
                end
              endcase
            end
            PH_VARINT: nx.phase = PH_KEY;
            default: begin
              // length of a length-delimited value
              if (acc > 64'(left)) begin
                nx.phase   = PH_DONE;
                nx.outcome = OC_MALFORMED;
              end else if (cur.field_num == PATCH_FIELD && acc == PATCH_LEN) begin
                nx.outcome    = OC_PATCHED;
                nx.code_index = '0;
                nx.phase      = PH_PATCH;
              end else if (acc == '0) begin
                nx.phase = PH_KEY;
              end else begin
                skip_next = LW'(acc);
                nx.phase  = PH_SKIP;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    // message end while still scanning
    if (nx.outcome == OC_SCAN && (consumed >= {1'b0, lenc} || last_in)) begin
      nx.outcome = at_boundary(nx) ? OC_NO_FIELD : OC_MALFORMED;
      nx.phase   = PH_DONE;
    end

    res_outcome = nx.outcome;

    // rearm after the final byte, else advance the saturating position
    if (last_in) begin
      nx        = SCAN_REARM;
      skip_next = '0;
      pos_next  = '0;
    end else if (pos < PW'(MAX_MESSAGE_BYTES)) begin
      pos_next = pos + 1'b1;
    end

    st_next = nx;
  end

  // Output byte: code byte while patching
  always_comb begin
    code_arr = code;
    out_byte = body_byte;
    replaced = 1'b0;
    if (cur.phase == PH_PATCH) begin
      replaced = 1'b1;
      out_byte = (cur.code_index < 5'(CODE_BYTES)) ? code_arr[cur.code_index] : 8'h00;
    end
  end

endmodule

@@ hdl/protobuf_field_scan_patch_core.sv @@
`timescale 1ns / 1ps
// A result is registered and valid in the cycle after its byte is accepted.
// One byte per cycle while the sink keeps taking results; the scanner state
// register is updated once per accepted byte and the result register frees
// as the sink takes it. Reset (rst, synchronous): scanner rearmed, code
// registers zero, result register empty.
// ----------------------------------------------------------------------------
// protobuf_field_scan_patch_core
// Byte-stream protobuf field scanner that overwrites the first 20-byte
// field 2 with a configured code.
// ----------------------------------------------------------------------------
module protobuf_field_scan_patch_core #(
  parameter int MAX_MESSAGE_BYTES = 65536
) (
  input logic        clk,
  input logic        rst,
  pfsp_body_if.sink     body,
  pfsp_result_if.source result,
  pfsp_cfg_if.sink      cfg
);
  import pfsp_pkg::*;

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int LW = (PW > 17) ? PW : 17;

  scan_state_t   st;
  scan_state_t   st_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [LW-1:0] skip_cnt;
  logic [LW-1:0] skip_next;
  logic [63:0]   code_low;
  logic [63:0]   code_mid;
  logic [31:0]   code_high;
  logic [7:0]    step_byte;
  logic          step_replaced;
  outcome_t      step_outcome;
  logic          res_valid;
  logic          body_acc;

  assign body.ready   = !res_valid || result.ready;
  assign body_acc     = body.valid && body.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;

  pfsp_step #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
    .PW(PW),
    .LW(LW)
  ) u_step (
    .cur        (st),
    .pos        (pos),
    .skip_cnt   (skip_cnt),
    .code       ({code_high, code_mid, code_low}),
    .body_byte  (body.body_byte),
    .body_length(body.body_length),
    .last_in    (body.last_in),
    .st_next    (st_next),
    .pos_next   (pos_next),
    .skip_next  (skip_next),
    .out_byte   (step_byte),
    .replaced   (step_replaced),
    .res_outcome(step_outcome)
  );

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= SCAN_REARM;
      pos      <= '0;
      skip_cnt <= '0;
    end else if (body_acc) begin
      st       <= st_next;
      pos      <= pos_next;
      skip_cnt <= skip_next;
    end
  end

  // Code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_low  <= '0;
      code_mid  <= '0;
      code_high <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_CODE_LOW:  code_low  <= cfg.wr_data;
        CFG_CODE_MID:  code_mid  <= cfg.wr_data;
        CFG_CODE_HIGH: code_high <= cfg.wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (body_acc) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (body_acc) begin
      result.out_byte <= step_byte;
      result.replaced <= step_replaced;
      result.outcome  <= step_outcome;
      result.last_out <= body.last_in;
    end
  end

`ifndef SYNTHESIS
  a_replaced_patched: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.replaced |-> result.outcome == OC_PATCHED)
    else $error("replaced byte without patched outcome");

  a_patch_outcome: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_PATCH |-> st.outcome == OC_PATCHED)
    else $error("patch phase with wrong outcome");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    body_acc && body.last_in |=> pos == '0 && st.phase == PH_KEY && st.outcome == OC_SCAN)
    else $error("scanner not rearmed after final byte");

  a_code_index: assert property (@(posedge clk) disable iff (rst)
    st.code_index <= 5'(CODE_BYTES))
    else $error("code index out of range");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the protobuf field scan and patch core. Random and
// hand-picked encoded messages go in one byte per request; a scoreboard
// tracks the scanner state and the code registers, predicts every output
// byte and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module testbench;
  import pfsp_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PRESSURE_CYCLES = 200;
  localparam int PRESSURE_AFTER  = 300;
  localparam int TARGET_ITEMS    = 1000;
  localparam int MAX_MSG_BYTES   = 65536;

  // wire types the scanner rejects
  localparam logic [2:0] WT_SGROUP    = 3'd3;
  localparam logic [2:0] WT_EGROUP    = 3'd4;
  localparam logic [2:0] WT_RESERVED6 = 3'd6;
  localparam logic [2:0] WT_RESERVED7 = 3'd7;

  // register index with nothing behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // how body_length relates to the bytes actually sent
  typedef enum int {
    LEN_EXACT,
    LEN_PAST_END,
    LEN_LONGER,
    LEN_SHORTER,
    LEN_SHRINKS
  } len_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       replaced;
    outcome_t   outcome;
    logic       last_out;
  } patched_byte_t;

  // Scanner prediction and result checking
  class patch_scoreboard;
    localparam int unsigned MaxMsgBytes = 65536;

    logic [63:0] code_low;
    logic [63:0] code_mid;
    logic [31:0] code_high;

    phase_t      phase;
    int unsigned pos;
    logic [63:0] accum;
    int unsigned shift;
    logic [31:0] field_num;
    int unsigned skip_left;
    int unsigned code_idx;
    outcome_t    status;

    patched_byte_t expected_bytes[$];
    int            errors;
    int            checked;

    function new();
      code_low  = '0;
      code_mid  = '0;
      code_high = '0;
      errors    = 0;
      checked   = 0;
      rearm();
    endfunction

    function void rearm();
      phase     = PH_KEY;
      pos       = 0;
      accum     = '0;
      shift     = 0;
      field_num = '0;
      skip_left = 0;
      code_idx  = 0;
      status    = OC_SCAN;
    endfunction

    function void set_code(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_CODE_LOW:  code_low  = data;
        CFG_CODE_MID:  code_mid  = data;
        CFG_CODE_HIGH: code_high = data[31:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [7:0] code_byte(int unsigned i);
      if (i < 8) return code_low[8*i +: 8];
      if (i < 16) return code_mid[8*(i-8) +: 8];
      if (i < 20) return code_high[8*(i-16) +: 8];
      return 8'h00;
    endfunction

    function void halt(outcome_t oc);
      status = oc;
      phase  = PH_DONE;
    endfunction

    // nothing half read: no key byte and no value outstanding
    function bit at_rest();
      return phase == PH_KEY && shift == 0;
    endfunction

    // Advance the scanner by one accepted byte and queue the output it causes
    function void note_byte(logic [7:0] b, logic [16:0] len_in, logic last);
      int unsigned   msg_len;
      int unsigned   consumed;
      int unsigned   left;
      int unsigned   nbytes;
      logic [63:0]   v;
      patched_byte_t r;

      msg_len    = (len_in > MaxMsgBytes) ? MaxMsgBytes : len_in;
      r.out_byte = b;
      r.replaced = 1'b0;

      // byte arrives past the message length while still scanning
      if (status == OC_SCAN && pos >= msg_len) halt(at_rest() ? OC_NO_FIELD : OC_MALFORMED);

      consumed = pos + 1;
      left     = (msg_len > consumed) ? msg_len - consumed : 0;

      case (phase)
        PH_PATCH: begin
          r.out_byte = code_byte(code_idx);
          r.replaced = 1'b1;
          code_idx++;
          if (code_idx >= CODE_BYTES) phase = PH_DONE;
        end
        PH_SKIP: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) phase = PH_KEY;
        end
        PH_KEY, PH_VARINT, PH_LEN: begin
          if (shift < 64) accum = accum | (64'(b[6:0]) << shift);
          if (b[7]) begin
            shift += 7;
            if (shift >= 64) halt(OC_MALFORMED);
          end else begin
            v     = accum;
            accum = '0;
            shift = 0;
            if (phase == PH_KEY) begin
              field_num = v[34:3];
              case (v[2:0])
                WT_VARINT: phase = PH_VARINT;
                WT_FIXED64, WT_FIXED32: begin
                  nbytes = (v[2:0] == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                  if (nbytes > left) halt(OC_MALFORMED);
                  else begin
                    skip_left = nbytes;
                    phase     = PH_SKIP;
                  end
                end
                WT_LEN: phase = PH_LEN;
                default: halt(OC_MALFORMED);
              endcase
            end else if (phase == PH_VARINT) begin
              phase = PH_KEY;
            end else begin
              if (v > 64'(left)) halt(OC_MALFORMED);
              else if (field_num == PATCH_FIELD && v == PATCH_LEN) begin
                status   = OC_PATCHED;
                code_idx = 0;
                phase    = PH_PATCH;
              end else if (v == 0) phase = PH_KEY;
              else begin
                skip_left = v[31:0];
                phase     = PH_SKIP;
              end
            end
          end
        end
        default: ;
      endcase

      // message end by length or by end mark
      if (status == OC_SCAN && (consumed >= msg_len || last))
        halt(at_rest() ? OC_NO_FIELD : OC_MALFORMED);

      r.outcome  = status;
      r.last_out = last;
      expected_bytes.push_back(r);

      if (last) rearm();
      else if (pos < MaxMsgBytes) pos++;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [7:0] ob, logic rep, logic [1:0] oc, logic lo);
      patched_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("output byte %02h with no request outstanding", ob));
        return;
      end
      want = expected_bytes.pop_front();
      if (ob !== want.out_byte)
        report($sformatf("byte %0d out_byte %02h, want %02h", checked, ob, want.out_byte));
      if (rep !== want.replaced)
        report($sformatf("byte %0d replaced %b, want %b", checked, rep, want.replaced));
      if (oc !== want.outcome)
        report($sformatf("byte %0d outcome %0d, want %0d", checked, oc, want.outcome));
      if (lo !== want.last_out)
        report($sformatf("byte %0d last_out %b, want %b", checked, lo, want.last_out));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfsp_body_if   body_ch ();
  pfsp_result_if result_ch ();
  pfsp_cfg_if    cfg_ch ();

  protobuf_field_scan_patch_core #(
    .MAX_MESSAGE_BYTES(MAX_MSG_BYTES)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .body  (body_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  patch_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          body_quiet = 1'b0;
  logic [7:0]  msg_bytes[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.out_byte, result_ch.replaced, result_ch.outcome,
                      result_ch.last_out);
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Output side: random stalls, quiet windows, and one long hold-off
  initial begin : result_sink
    int stall;
    int window;
    bit quiet;
    bit pressed;
    stall   = 0;
    window  = 0;
    quiet   = 1'b0;
    pressed = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && sb.checked >= PRESSURE_AFTER) begin
        // hold long enough for the core to back up into its input
        pressed = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end
      window++;
      if (window == 64) begin
        window = 0;
        quiet  = ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall = idle_len();
      end
    end
  end

  // One byte request; returns at the edge that accepts it
  task automatic send_byte(logic [7:0] b, logic [16:0] len, logic last);
    int gap;
    gap = (body_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      body_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_ch.valid       <= 1'b1;
    body_ch.body_byte   <= b;
    body_ch.body_length <= len;
    body_ch.last_in     <= last;
    do @(posedge clk); while (!body_ch.ready);
    sb.note_byte(b, len, last);
    items_sent++;
  endtask

  task automatic body_rest();
    @(negedge clk);
    body_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    body_rest();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_code(idx, data);
  endtask

  task automatic program_code(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    write_reg(CFG_CODE_LOW, lo);
    write_reg(CFG_CODE_MID, mid);
    write_reg(CFG_CODE_HIGH, hi);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Code patterns: all zeros, all ones, then random
  task automatic reprogram(int sel);
    case (sel % 4)
      0: program_code('0, '0, '0);
      1: program_code('1, '1, '1);
      default: program_code({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    endcase
  endtask

  task automatic put_random(int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endtask

  // Varint, optionally stretched with redundant continuation bytes
  task automatic put_varint(logic [63:0] v, int pad);
    int          n;
    logic [63:0] t;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    n += pad;
    for (int i = 0; i < n; i++) begin
      msg_bytes.push_back({(i < n - 1), v[6:0]});
      v = v >> 7;
    end
  endtask

  // Random message: mostly well-formed fields, sometimes damaged afterwards
  task automatic build_message();
    int          nfields;
    int          patch_at;
    int          kind;
    int          len_val;
    int          k;
    logic [60:0] fnum;
    logic [2:0]  bad_wt[4];
    bad_wt   = '{WT_SGROUP, WT_EGROUP, WT_RESERVED6, WT_RESERVED7};
    msg_bytes.delete();
    nfields  = $urandom_range(1, 5);
    patch_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nfields - 1) : -1;
    for (int f = 0; f < nfields; f++) begin
      if (f == patch_at || $urandom_range(0, 19) == 0) begin
        // target field; upper key bits above 32 are dropped by the scanner
        fnum = ($urandom_range(0, 3) == 0) ? {29'($urandom), 32'd2} : 61'd2;
        put_varint({fnum, WT_LEN}, 0);
        put_varint(PATCH_LEN, ($urandom_range(0, 3) == 0) ? 1 : 0);
        put_random(CODE_BYTES);
      end else begin
        fnum = ($urandom_range(0, 4) == 0) ? 61'({$urandom, $urandom} >> $urandom_range(3, 63))
                                          : 61'($urandom_range(1, 15));
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
          put_varint({fnum, WT_VARINT}, 0);
          put_varint({$urandom, $urandom} >> $urandom_range(0, 63),
                     ($urandom_range(0, 9) == 0) ? 1 : 0);
        end else if (kind < 9) begin
          put_varint({fnum, WT_FIXED64}, 0);
          put_random(FIXED64_BYTES);
        end else if (kind < 12) begin
          put_varint({fnum, WT_FIXED32}, 0);
          put_random(FIXED32_BYTES);
        end else if (kind < 19) begin
          len_val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(19, 21);
          put_varint({fnum, WT_LEN}, 0);
          put_varint(64'(len_val), 0);
          put_random(len_val);
        end else begin
          put_varint({fnum, bad_wt[$urandom_range(0, 3)]}, 0);
        end
      end
    end

    // damage about one message in four
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: if (msg_bytes.size() > 1) begin
          k = $urandom_range(1, (msg_bytes.size() > 6) ? 5 : msg_bytes.size() - 1);
          repeat (k) void'(msg_bytes.pop_back());
        end
        1: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
        2: begin
          // key varint that runs past ten bytes
          repeat (11) msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
          msg_bytes.push_back(8'($urandom_range(0, 127)));
        end
        default: put_varint({61'($urandom_range(1, 15)), bad_wt[$urandom_range(0, 3)]}, 0);
      endcase
    end
    if (msg_bytes.size() == 0) msg_bytes.push_back(8'($urandom));
  endtask

  // Send the built message with one of the length arrangements
  task automatic send_message();
    int          size;
    int          r;
    int          extra;
    int          short_len;
    len_mode_t   mode;
    logic [16:0] len;
    size = msg_bytes.size();
    r    = $urandom_range(0, 99);
    if (r < 60) mode = LEN_EXACT;
    else if (r < 72) mode = LEN_PAST_END;
    else if (r < 84) mode = LEN_LONGER;
    else if (r < 94) mode = LEN_SHORTER;
    else mode = LEN_SHRINKS;
    if (size < 2 && (mode == LEN_SHORTER || mode == LEN_SHRINKS)) mode = LEN_EXACT;

    len       = 17'(size);
    short_len = 1;
    case (mode)
      LEN_LONGER:
        len = ($urandom_range(0, 3) == 0) ? 17'd65536 : 17'($urandom_range(size + 1, 65536));
      LEN_SHORTER: len = 17'($urandom_range(1, size - 1));
      LEN_SHRINKS: short_len = $urandom_range(1, size / 2);
      default: ;
    endcase

    body_quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++)
      send_byte(msg_bytes[i], (mode == LEN_SHRINKS && i >= size / 2) ? 17'(short_len) : len,
                (i == size - 1) && mode != LEN_PAST_END);
    if (mode == LEN_PAST_END) begin
      // bytes beyond the stated length, end mark on the last
      extra = $urandom_range(1, 3);
      for (int j = 0; j < extra; j++) send_byte(8'($urandom), len, j == extra - 1);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int msgs;
    body_ch.valid       = 1'b0;
    body_ch.body_byte   = '0;
    body_ch.body_length = '0;
    body_ch.last_in     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.reg_index    = CFG_CODE_LOW;
    cfg_ch.wr_data      = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_code({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    // a write to the unused index must change nothing
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    @(negedge clk);
    cfg_ch.valid <= 1'b0;

    body_quiet = 1'b0;
    // one-byte message: varint key then the end
    send_byte(8'h00, 17'd1, 1'b1);
    // zero-length value goes straight back to key reading
    send_byte(8'h0A, 17'd2, 1'b0);
    send_byte(8'h00, 17'd2, 1'b1);
    // rejected wire type at the largest length
    send_byte(8'h0B, 17'd65536, 1'b1);
    // key varint with its continuation bit still set on the tenth byte
    for (int i = 0; i < VARINT_MAX_BYTES; i++)
      send_byte(8'hFF, 17'd65536, i == VARINT_MAX_BYTES - 1);
    // fixed64 with only four bytes left
    send_byte(8'h09, 17'd5, 1'b1);
    // clean end by length, then a stray byte past it
    send_byte(8'h08, 17'd2, 1'b0);
    send_byte(8'h7F, 17'd2, 1'b0);
    send_byte(8'h12, 17'd2, 1'b1);
    // length drops below the position mid-value
    send_byte(8'h08, 17'd5, 1'b0);
    send_byte(8'h01, 17'd1, 1'b1);

    wait_drained();
    reprogram(1);

    msgs = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (msgs % 8 == 7) begin
        wait_drained();
        reprogram(msgs / 8);
      end
      build_message();
      send_message();
      msgs++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pfsp_pkg.sv
hdl/pfsp_body_if.sv
hdl/pfsp_result_if.sv
hdl/pfsp_cfg_if.sv
hdl/pfsp_step.sv
hdl/protobuf_field_scan_patch_core.sv
tb/testbench.sv
